@@ sv/small_set_membership_table_assert.svh @@
// Assertion macros used by the set membership table top level.
// Every macro samples on the rising edge of clock and is disabled during reset.
`ifndef SMALL_SET_MEMBERSHIP_TABLE_ASSERT_SVH
`define SMALL_SET_MEMBERSHIP_TABLE_ASSERT_SVH

// Property holds at every sampled edge outside reset.
`define SSMT_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Trigger implies the consequence at the next edge.
`define SSMT_ASSERT_NEXT(lbl, trig, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cons)) else $error(msg);

`endif

@@ sv/ssmt_pkg.sv @@
// Package for the set membership table: sizes, opcodes and cell control.
// No dependencies.
`default_nettype none

package ssmt_pkg;

   // Number of cells in the chain (set capacity)
   localparam int unsigned CAPACITY = 64;
   // Width of the internal entry counter, holds 0..CAPACITY
   localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
   // Width of the reported entry count
   localparam int unsigned ENTRY_COUNT_W = 7;
   localparam int unsigned VALUE_W = 32;
   localparam int unsigned OPCODE_W = 2;

   typedef enum logic [OPCODE_W-1:0] {
      OP_ADD    = 2'd0,
      OP_QUERY  = 2'd1,
      OP_REMOVE = 2'd2
   } op_type;

   // Per-cell control issued by the sequencer
   typedef struct packed {
      logic cmp;    // compare stored entry against the broadcast value
      logic add;    // first empty cell takes the broadcast value
      logic shift;  // take entry and valid from the upper neighbor
   } cell_ctl_type;

endpackage

`default_nettype wire

@@ sv/ssmt_cell.sv @@
// One storage cell of the set membership table chain.
// Depends on ssmt_pkg (widths, cell control struct).
`default_nettype none

module ssmt_cell (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire ssmt_pkg::cell_ctl_type       ctl,
   input  wire logic [ssmt_pkg::VALUE_W-1:0] value,
   input  wire logic                         prev_valid,
   input  wire logic [ssmt_pkg::VALUE_W-1:0] next_entry,
   input  wire logic                         next_valid,
   output logic [ssmt_pkg::VALUE_W-1:0]      entry,
   output logic                              valid,
   output logic                              hit
);

   logic [ssmt_pkg::VALUE_W-1:0] entry_ff, entry_in;
   logic                         valid_ff, valid_in;
   logic                         hit_ff, hit_in;

   // Next state: latch the compare result, shift down on remove, fill the first empty slot on add
   always_comb begin
      entry_in = entry_ff;
      valid_in = valid_ff;
      hit_in   = hit_ff;
      if (ctl.cmp) begin
         hit_in = valid_ff && (entry_ff == value);
      end
      if (ctl.shift) begin
         entry_in = next_entry;
         valid_in = next_valid;
      end else if (ctl.add && prev_valid && !valid_ff) begin
         entry_in = value;
         valid_in = 1'b1;
      end
   end

   // Valid is control state; entry and hit are payload
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      entry_ff <= entry_in;
      hit_ff   <= hit_in;
   end

   assign entry = entry_ff;
   assign valid = valid_ff;
   assign hit   = hit_ff;

endmodule

`default_nettype wire

@@ sv/small_set_membership_table.sv @@
// Top level of the set membership table: sequencer plus a chain of storage cells.
// Depends on ssmt_pkg, ssmt_cell and small_set_membership_table_assert.svh.
//
// Usage:
//   Issue an item by raising start with req_opcode (add, query, remove) and
//   req_value while busy is low; the item is taken at that clock edge.
//   busy is high after acceptance through the compare state, in which every
//   cell compares its entry with the value, and the update state, in which the
//   cells update (append to the first empty cell, or shift the cells above a
//   removed entry down by one).
//   The result appears on rsp_* with rsp_strobe high for exactly one cycle,
//   the cycle after the update state, and is taken at the end of that cycle.
//   A new item may be accepted in that same cycle; the block takes no new item
//   while an earlier one is still in the registered compare stage or the
//   update stage of the cell chain.
//   rsp_entry_count gives the element count after the operation, low 7 bits.
//   The receiver cannot stall; results are never held back.
//   Reset (synchronous, active high) empties the set by clearing every cell's
//   valid bit at once; no clearing pass is needed.
`default_nettype none

module small_set_membership_table (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  start,
   output logic                                       busy,
   input  wire logic [ssmt_pkg::OPCODE_W-1:0]         req_opcode,
   input  wire logic signed [ssmt_pkg::VALUE_W-1:0]   req_value,
   output logic                                       rsp_strobe,
   output logic                                       rsp_was_present,
   output logic                                       rsp_success,
   output logic [ssmt_pkg::ENTRY_COUNT_W-1:0]         rsp_entry_count
);

`include "small_set_membership_table_assert.svh"

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CMP,
      ST_APPLY
   } state_type;

   localparam int unsigned N = ssmt_pkg::CAPACITY;

   state_type                        state_ff, state_in;
   logic [ssmt_pkg::OPCODE_W-1:0]    op_ff, op_in;
   logic [ssmt_pkg::VALUE_W-1:0]     value_ff, value_in;
   logic [ssmt_pkg::CNT_W-1:0]       count_ff, count_in;
   logic                             strobe_ff, strobe_in;
   logic                             present_ff, present_in;
   logic                             success_ff, success_in;

   // Cell chain wiring
   logic [ssmt_pkg::VALUE_W-1:0]     cell_entry [N];
   logic [N-1:0]                     cell_valid;
   logic [N-1:0]                     cell_hit;
   logic [N-1:0]                     shift_mask;
   ssmt_pkg::cell_ctl_type           cell_ctl [N];

   logic                             present;
   logic                             full;
   logic                             do_add;
   logic                             do_remove;
   logic                             accept;
   logic [ssmt_pkg::CNT_W+ssmt_pkg::ENTRY_COUNT_W-1:0] count_ext;

   assign accept  = start && (state_ff == ST_IDLE);
   assign present = |cell_hit;
   assign full    = (count_ff == ssmt_pkg::CNT_W'(N));
   assign do_add    = (state_ff == ST_APPLY) && (op_ff == ssmt_pkg::OP_ADD)
                      && !present && !full;
   assign do_remove = (state_ff == ST_APPLY) && (op_ff == ssmt_pkg::OP_REMOVE) && present;

   // Cells at and above the single hit take their upper neighbor's contents
   assign shift_mask = do_remove ? ~(cell_hit - N'(1)) : '0;

   // Sequencer and result registers, next values
   always_comb begin
      state_in   = state_ff;
      op_in      = op_ff;
      value_in   = value_ff;
      count_in   = count_ff;
      strobe_in  = 1'b0;
      present_in = present_ff;
      success_in = success_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in    = req_opcode;
               value_in = req_value;
               state_in = ST_CMP;
            end
         end
         ST_CMP: begin
            state_in = ST_APPLY;
         end
         ST_APPLY: begin
            state_in   = ST_IDLE;
            strobe_in  = 1'b1;
            present_in = present;
            case (op_ff)
               ssmt_pkg::OP_ADD:    success_in = present || !full;
               ssmt_pkg::OP_QUERY:  success_in = present;
               ssmt_pkg::OP_REMOVE: success_in = present;
               default:             success_in = 1'b0;
            endcase
            if (do_add) begin
               count_in = count_ff + ssmt_pkg::CNT_W'(1);
            end else if (do_remove) begin
               count_in = count_ff - ssmt_pkg::CNT_W'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         strobe_ff <= strobe_in;
      end
      op_ff      <= op_in;
      value_ff   <= value_in;
      present_ff <= present_in;
      success_ff <= success_in;
   end

   // Chain of cells
   for (genvar i = 0; i < N; i++) begin : g_cell
      logic                         prev_valid_w;
      logic [ssmt_pkg::VALUE_W-1:0] next_entry_w;
      logic                         next_valid_w;

      if (i == 0) begin : g_first
         assign prev_valid_w = 1'b1;
      end else begin : g_mid
         assign prev_valid_w = cell_valid[i-1];
      end

      if (i == N - 1) begin : g_last
         assign next_entry_w = value_ff;
         assign next_valid_w = 1'b0;
      end else begin : g_inner
         assign next_entry_w = cell_entry[i+1];
         assign next_valid_w = cell_valid[i+1];
      end

      assign cell_ctl[i].cmp   = (state_ff == ST_CMP);
      assign cell_ctl[i].add   = do_add;
      assign cell_ctl[i].shift = shift_mask[i];

      ssmt_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (cell_ctl[i]),
         .value      (value_ff),
         .prev_valid (prev_valid_w),
         .next_entry (next_entry_w),
         .next_valid (next_valid_w),
         .entry      (cell_entry[i]),
         .valid      (cell_valid[i]),
         .hit        (cell_hit[i])
      );
   end

   assign count_ext       = {{ssmt_pkg::ENTRY_COUNT_W{1'b0}}, count_ff};
   assign busy            = (state_ff != ST_IDLE);
   assign rsp_strobe      = strobe_ff;
   assign rsp_was_present = present_ff;
   assign rsp_success     = success_ff;
   assign rsp_entry_count = count_ext[ssmt_pkg::ENTRY_COUNT_W-1:0];

   // Checks
   `SSMT_ASSERT(a_hit_single, !(state_ff == ST_APPLY) || $onehot0(cell_hit), "multiple cells hit")
   `SSMT_ASSERT(a_valid_packed, (cell_valid & (cell_valid + N'(1))) == '0, "valid cells not packed")
   `SSMT_ASSERT(a_count_range, count_ff <= ssmt_pkg::CNT_W'(N), "count above capacity")
   `SSMT_ASSERT(a_count_match, $countones(cell_valid) == int'(count_ff), "count and cells disagree")
   `SSMT_ASSERT_NEXT(a_accept_result, accept, ##2 rsp_strobe, "result not three cycles on")

endmodule

`default_nettype wire
